[rtl/dcwm_pkg.sv]
// shared constants and a helper for the dark channel window minimum block
package dcwm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_PATCH  = 8;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 10;
  localparam int PATCH_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH  = 2'd2;

  localparam logic [CFG_W-1:0]   RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]   RST_HEIGHT = 11'd480;
  localparam logic [PATCH_W-1:0] RST_PATCH  = 4'd8;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/dark_channel_window_min.sv]
// dark channel window minimum: min of r/g/b over a clipped p x p window, streamed
// a pixel word is taken while idle; each result it causes then costs its window
// size in line store reads (one per cycle, rows x cols up to p*p) plus a drain state and
// an emit state that waits for out_ready; a corner pixel causes up to p*p such results
// input is not taken again until the last result word has been taken
// synchronous reset clears position, control and configuration registers to their defaults;
// the line store is not cleared since a window only covers written entries
module dark_channel_window_min
  import dcwm_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_PATCH  = DEF_MAX_PATCH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     dark_value,
  output logic [POS_W-1:0]     out_row,
  output logic [POS_W-1:0]     out_col,
  output logic                 run_last
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1) + 1;
  localparam int HW    = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int SW    = (MAX_PATCH > 1) ? $clog2(MAX_PATCH) : 1;
  localparam int SW1   = SW + 1;
  localparam int DEPTH = MAX_PATCH * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WCW   = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCW   = (HW > CFG_W) ? HW : CFG_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t state;

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [PATCH_W-1:0] patch_size;

  logic [YW-1:0] row_count;
  logic [XW-1:0] col_count;
  logic [SW-1:0] row_slot;

  // current pixel position and anchor ranges
  logic [YW-1:0] pr, ai, rhi, rr;
  logic [XW-1:0] pc, aj, clo, chi, cc;
  logic [SW-1:0] aslot, rslot;
  logic [PIX_W-1:0] acc;
  logic rd_pend;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] q;
  logic [AW-1:0]    waddr, raddr;
  logic             we;

  // clamped geometry
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [PATCH_W-1:0] p;

  always_comb begin
    if (image_width == '0) w = WW'(1);
    else if (WCW'(image_width) > WCW'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
    else w = WW'(image_width);
    if (image_height == '0) h = HW'(1);
    else if (HCW'(image_height) > HCW'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
    else h = HW'(image_height);
    if (patch_size == '0) p = PATCH_W'(1);
    else if (patch_size > PATCH_W'(MAX_PATCH)) p = PATCH_W'(MAX_PATCH);
    else p = patch_size;
  end

  // window ranges for the incoming pixel
  logic          r_last, c_last, rows_ok, cols_ok;
  logic [HW-1:0] rlo_x;
  logic [WW-1:0] clo_x;
  logic [YW-1:0] rlo_n, rdiff;
  logic [XW-1:0] clo_n;
  logic [SW1-1:0] slot_x;
  logic [SW-1:0] aslot_n;
  logic [PIX_W-1:0] pix_min;
  logic in_fire;

  always_comb begin
    r_last = (HW'(row_count) == h - HW'(1));
    c_last = (WW'(col_count) == w - WW'(1));
    if (r_last) begin
      rows_ok = 1'b1;
      rlo_x = (h > HW'(p)) ? h - HW'(p) : '0;
    end else begin
      rows_ok = (HW'(row_count) + HW'(1) >= HW'(p));
      rlo_x = HW'(row_count) + HW'(1) - HW'(p);
    end
    if (c_last) begin
      cols_ok = 1'b1;
      clo_x = (w > WW'(p)) ? w - WW'(p) : '0;
    end else begin
      cols_ok = (WW'(col_count) + WW'(1) >= WW'(p));
      clo_x = WW'(col_count) + WW'(1) - WW'(p);
    end
    rlo_n = YW'(rlo_x);
    clo_n = XW'(clo_x);
    rdiff = row_count - rlo_n;
    if (SW1'(row_slot) >= SW1'(rdiff)) slot_x = SW1'(row_slot) - SW1'(rdiff);
    else slot_x = SW1'(row_slot) + SW1'(MAX_PATCH) - SW1'(rdiff);
    aslot_n = SW'(slot_x);
    pix_min = min2(min2(red, green), blue);
  end

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state == S_EMIT);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (SW1'(s) == SW1'(MAX_PATCH - 1)) ? '0 : s + SW'(1);
  endfunction

  // next anchor
  logic          anchor_done;
  logic [YW-1:0] na_i;
  logic [XW-1:0] na_j;
  logic [SW-1:0] na_slot;
  logic          scan_end;

  always_comb begin
    anchor_done = (ai == rhi) && (aj == chi);
    if (aj == chi) begin
      na_j = clo;
      na_i = ai + YW'(1);
      na_slot = slot_inc(aslot);
    end else begin
      na_j = aj + XW'(1);
      na_i = ai;
      na_slot = aslot;
    end
    scan_end = (rr == pr) && (cc == pc);
  end

  assign we    = in_fire;
  assign waddr = AW'(AW'(row_slot) * AW'(MAX_WIDTH) + AW'(col_count));
  assign raddr = AW'(AW'(rslot) * AW'(MAX_WIDTH) + AW'(cc));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= pix_min;
    q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      patch_size   <= RST_PATCH;
      row_count    <= '0;
      col_count    <= '0;
      row_slot     <= '0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH: begin
            image_width <= cfg_data;
            row_count <= '0; col_count <= '0; row_slot <= '0;
          end
          CFG_HEIGHT: begin
            image_height <= cfg_data;
            row_count <= '0; col_count <= '0; row_slot <= '0;
          end
          CFG_PATCH: begin
            patch_size <= PATCH_W'(cfg_data);
            row_count <= '0; col_count <= '0; row_slot <= '0;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pr <= row_count;
            pc <= col_count;
            ai <= rlo_n;
            rhi <= r_last ? row_count : rlo_n;
            aj <= clo_n;
            clo <= clo_n;
            chi <= c_last ? col_count : clo_n;
            aslot <= aslot_n;
            rr <= rlo_n;
            rslot <= aslot_n;
            cc <= clo_n;
            acc <= '1;
            if (c_last) begin
              col_count <= '0;
              if (r_last) begin
                row_count <= '0;
                row_slot <= '0;
              end else begin
                row_count <= row_count + YW'(1);
                row_slot <= slot_inc(row_slot);
              end
            end else begin
              col_count <= col_count + XW'(1);
            end
            if (rows_ok && cols_ok) state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_pend) acc <= min2(acc, q);
          if (scan_end) begin
            state <= S_DRAIN;
          end else if (cc == pc) begin
            cc <= aj;
            rr <= rr + YW'(1);
            rslot <= slot_inc(rslot);
          end else begin
            cc <= cc + XW'(1);
          end
        end
        S_DRAIN: begin
          dark_value <= min2(acc, q);
          out_row <= POS_W'(ai);
          out_col <= POS_W'(aj);
          run_last <= anchor_done;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (anchor_done) begin
              state <= S_IDLE;
            end else begin
              ai <= na_i;
              aj <= na_j;
              aslot <= na_slot;
              rr <= na_i;
              cc <= na_j;
              rslot <= na_slot;
              acc <= '1;
              state <= S_SCAN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
